// File: rtl/multipart_boundary_parser_unit_assert.svh
// ----------------------------------------------------------------------------
// multipart boundary parser assertion macros
// clocked property checks, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef MULTIPART_BOUNDARY_PARSER_UNIT_ASSERT_SVH
`define MULTIPART_BOUNDARY_PARSER_UNIT_ASSERT_SVH

`ifndef SYNTH
`define MBP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mbp assertion failed");
`define MBP_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("mbp forbidden condition seen");
`else
`define MBP_ASSERT(label, clk, rst_n, prop)
`define MBP_NEVER(label, clk, rst_n, expr)
`endif

`endif

// File: rtl/mbp_pkg.sv
// ----------------------------------------------------------------------------
// mbp_pkg
// shared constants, types and helpers of the multipart boundary parser
// ----------------------------------------------------------------------------
package mbp_pkg;

    localparam int DELIM_MAX = 76;
    localparam int CNT_W     = $clog2(DELIM_MAX + 1);

    localparam logic [CNT_W-1:0] DELIM_MAX_CNT = CNT_W'(DELIM_MAX);
    localparam logic [CNT_W-1:0] HEAD_LEN      = CNT_W'(4);
    localparam logic [CNT_W-1:0] HDR_HOLD      = CNT_W'(3);

    localparam logic [7:0] CHAR_CR   = 8'h0d;
    localparam logic [7:0] CHAR_LF   = 8'h0a;
    localparam logic [7:0] CHAR_DASH = 8'h2d;

    localparam logic [2:0] KIND_HDR_BYTE   = 3'd0;
    localparam logic [2:0] KIND_BODY_BYTE  = 3'd1;
    localparam logic [2:0] KIND_HDR_BEGIN  = 3'd2;
    localparam logic [2:0] KIND_BODY_BEGIN = 3'd3;
    localparam logic [2:0] KIND_FINAL      = 3'd4;
    localparam logic [2:0] KIND_TOO_LONG   = 3'd5;

    typedef enum logic [1:0] {
        ROLE_HIST,
        ROLE_TAIL,
        ROLE_IDLE
    } cell_role_t;

    typedef struct packed {
        logic       shift;
        logic       entry;
        cell_role_t role;
        logic       pat_we;
        logic [7:0] pat_wdata;
        logic       use_fixed;
        logic [7:0] fixed_byte;
    } cell_ctl_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
    } result_t;

    // CR LF CR LF
    function automatic logic [7:0] hdr_end_byte(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = CHAR_CR;
            2'd1:    r = CHAR_LF;
            2'd2:    r = CHAR_CR;
            default: r = CHAR_LF;
        endcase
        return r;
    endfunction

    // CR LF - -
    function automatic logic [7:0] delim_head_byte(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = CHAR_CR;
            2'd1:    r = CHAR_LF;
            default: r = CHAR_DASH;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/mbp_cell.sv
// ----------------------------------------------------------------------------
// mbp_cell
// one window byte and one delimiter byte with local compare
// ----------------------------------------------------------------------------
module mbp_cell
(
    input  logic                clk,
    input  mbp_pkg::cell_ctl_t  ctl,
    input  logic [7:0]          in_byte,
    input  logic [7:0]          neighbor_byte,
    output logic [7:0]          data,
    output logic                match
);

    logic [7:0] data_reg;
    logic [7:0] data_next;
    logic [7:0] pat_reg;
    logic [7:0] pat_next;
    logic [7:0] pat;

    always_comb
    begin
        data_next = data_reg;
        pat_next  = pat_reg;
        if (ctl.shift)
        begin
            data_next = ctl.entry ? in_byte : neighbor_byte;
        end
        if (ctl.pat_we)
        begin
            pat_next = ctl.pat_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        pat_reg  <= pat_next;
    end

    assign pat = ctl.use_fixed ? ctl.fixed_byte : pat_reg;

    always_comb
    begin
        case (ctl.role)
            mbp_pkg::ROLE_HIST: match = (data_reg == pat);
            mbp_pkg::ROLE_TAIL: match = (in_byte == pat);
            default:            match = 1'b1;
        endcase
    end

    assign data = data_reg;

endmodule

// File: rtl/mbp_outq.sv
// ----------------------------------------------------------------------------
// mbp_outq
// two-entry result queue between the parser and the output stream
// ----------------------------------------------------------------------------
`include "multipart_boundary_parser_unit_assert.svh"

module mbp_outq
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  mbp_pkg::result_t  wr_data,
    output logic              full,
    output logic              rd_valid,
    input  logic              rd_ready,
    output mbp_pkg::result_t  rd_data
);

    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    mbp_pkg::result_t slot_reg [2];
    logic             rd_fire;

    assign rd_fire = rd_valid && rd_ready;

    always_comb
    begin
        count_next  = count_reg + {1'b0, wr_en} - {1'b0, rd_fire};
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_fire;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign full     = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = slot_reg[rd_ptr_reg];

    `MBP_NEVER(a_outq_overflow, clk, rst_n, wr_en && count_reg == 2'd2)
    `MBP_NEVER(a_outq_count_range, clk, rst_n, count_reg == 2'd3)
    `MBP_ASSERT(a_outq_drain, clk, rst_n, (rd_fire && !wr_en) |=> count_reg == $past(count_reg) - 2'd1)

endmodule

// File: rtl/multipart_boundary_parser_unit.sv
// ----------------------------------------------------------------------------
// multipart_boundary_parser_unit
// multipart body parser: boundary capture, header and body release, delimiter
// detection over a chain of byte cells
// ----------------------------------------------------------------------------
// channel   dir  tdata                tuser      tlast
// s_*       in   in_byte[7:0]         -          -
// m_*       out  out_byte[7:0]        kind[2:0]  last_of_run
//
// one byte per cycle while s_tready is high; every compare of the delimiter
// window happens in parallel across the cell chain, so the chain's
// and-reduction sets the path; each byte causes at most one result, which enters
// a two-entry queue; s_tready drops only while that queue holds two results
// reset clears control state; cell contents are valid once written
// ----------------------------------------------------------------------------
`include "multipart_boundary_parser_unit_assert.svh"

module multipart_boundary_parser_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte[7:0]
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte[7:0]
    output logic [2:0] m_tuser,   // kind[2:0]
    output logic       m_tlast
);

    typedef enum logic [2:0] {
        PH_SEARCH  = 3'd0,
        PH_CAPTURE = 3'd1,
        PH_HEADERS = 3'd2,
        PH_BODY    = 3'd3,
        PH_AFTER   = 3'd4,
        PH_EPILOG  = 3'd5
    } phase_t;

    localparam int N  = mbp_pkg::DELIM_MAX;
    localparam int CW = mbp_pkg::CNT_W;

    phase_t          phase_reg, phase_next;
    logic [CW-1:0]   dlen_reg, dlen_next;
    logic [CW-1:0]   fill_reg, fill_next;
    logic            after_cnt_reg, after_cnt_next;
    logic            first_dash_reg, first_dash_next;
    logic            prev_dash_reg, prev_dash_next;
    logic            prev_cr_reg, prev_cr_next;

    logic            fire;
    logic [7:0]      b;
    logic [CW-1:0]   hold;
    logic [CW-1:0]   hold_m1;
    logic [CW-1:0]   dlen1;
    logic            win_full;
    logic            match_all;
    logic            push;
    logic            cap_start;
    logic            cr_we;
    logic            b_we;
    logic            emit;
    logic            q_full;
    mbp_pkg::result_t res;
    mbp_pkg::result_t q_out;

    logic [7:0]      cell_data  [N];
    logic [N-1:0]    cell_match;

    assign b        = s_tdata;
    assign s_tready = !q_full;
    assign fire     = s_tvalid && s_tready;

    assign hold      = (phase_reg == PH_HEADERS) ? mbp_pkg::HDR_HOLD : dlen_reg - 1'b1;
    assign hold_m1   = hold - 1'b1;
    assign win_full  = (fill_reg >= hold);
    assign match_all = (&cell_match) && win_full;
    assign dlen1     = dlen_reg + {{(CW-1){1'b0}}, prev_cr_reg};

    always_comb
    begin
        phase_next      = phase_reg;
        dlen_next       = dlen_reg;
        fill_next       = fill_reg;
        after_cnt_next  = after_cnt_reg;
        first_dash_next = first_dash_reg;
        prev_dash_next  = prev_dash_reg;
        prev_cr_next    = prev_cr_reg;
        push            = 1'b0;
        cap_start       = 1'b0;
        cr_we           = 1'b0;
        b_we            = 1'b0;
        emit            = 1'b0;
        res.kind        = mbp_pkg::KIND_HDR_BYTE;
        res.data        = 8'd0;

        if (fire)
        begin
            case (phase_reg)
                PH_SEARCH:
                begin
                    if (prev_dash_reg && b == mbp_pkg::CHAR_DASH)
                    begin
                        phase_next     = PH_CAPTURE;
                        prev_dash_next = 1'b0;
                        prev_cr_next   = 1'b0;
                        cap_start      = 1'b1;
                        dlen_next      = mbp_pkg::HEAD_LEN;
                    end
                    else
                    begin
                        prev_dash_next = (b == mbp_pkg::CHAR_DASH);
                    end
                end
                PH_CAPTURE:
                begin
                    if (prev_cr_reg && b == mbp_pkg::CHAR_LF)
                    begin
                        prev_cr_next = 1'b0;
                        if (dlen_reg <= mbp_pkg::HEAD_LEN)
                        begin
                            // empty boundary line, keep searching
                            phase_next     = PH_SEARCH;
                            dlen_next      = '0;
                            prev_dash_next = 1'b0;
                        end
                        else
                        begin
                            phase_next = PH_HEADERS;
                            fill_next  = '0;
                            emit       = 1'b1;
                            res.kind   = mbp_pkg::KIND_HDR_BEGIN;
                        end
                    end
                    else if (prev_cr_reg && dlen_reg >= mbp_pkg::DELIM_MAX_CNT)
                    begin
                        phase_next     = PH_SEARCH;
                        dlen_next      = '0;
                        prev_dash_next = 1'b0;
                        prev_cr_next   = 1'b0;
                        emit           = 1'b1;
                        res.kind       = mbp_pkg::KIND_TOO_LONG;
                    end
                    else
                    begin
                        // a held cr that was not part of crlf goes into the boundary
                        cr_we        = prev_cr_reg;
                        prev_cr_next = (b == mbp_pkg::CHAR_CR);
                        dlen_next    = dlen1;
                        if (b != mbp_pkg::CHAR_CR)
                        begin
                            if (dlen1 >= mbp_pkg::DELIM_MAX_CNT)
                            begin
                                phase_next     = PH_SEARCH;
                                dlen_next      = '0;
                                prev_dash_next = 1'b0;
                                emit           = 1'b1;
                                res.kind       = mbp_pkg::KIND_TOO_LONG;
                            end
                            else
                            begin
                                b_we      = 1'b1;
                                dlen_next = dlen1 + 1'b1;
                            end
                        end
                    end
                end
                PH_HEADERS, PH_BODY:
                begin
                    if (win_full)
                    begin
                        if (match_all)
                        begin
                            fill_next = '0;
                            if (phase_reg == PH_HEADERS)
                            begin
                                phase_next = PH_BODY;
                                emit       = 1'b1;
                                res.kind   = mbp_pkg::KIND_BODY_BEGIN;
                            end
                            else
                            begin
                                phase_next      = PH_AFTER;
                                after_cnt_next  = 1'b0;
                                first_dash_next = 1'b0;
                            end
                        end
                        else
                        begin
                            push      = 1'b1;
                            fill_next = hold;
                            emit      = 1'b1;
                            res.kind  = (phase_reg == PH_HEADERS) ? mbp_pkg::KIND_HDR_BYTE
                                                                  : mbp_pkg::KIND_BODY_BYTE;
                            res.data  = cell_data[0];
                        end
                    end
                    else
                    begin
                        push      = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                end
                PH_AFTER:
                begin
                    if (!after_cnt_reg)
                    begin
                        first_dash_next = (b == mbp_pkg::CHAR_DASH);
                        after_cnt_next  = 1'b1;
                    end
                    else
                    begin
                        after_cnt_next  = 1'b0;
                        fill_next       = '0;
                        first_dash_next = 1'b0;
                        emit            = 1'b1;
                        if (first_dash_reg && b == mbp_pkg::CHAR_DASH)
                        begin
                            phase_next = PH_EPILOG;
                            res.kind   = mbp_pkg::KIND_FINAL;
                        end
                        else
                        begin
                            phase_next = PH_HEADERS;
                            res.kind   = mbp_pkg::KIND_HDR_BEGIN;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SEARCH;
            dlen_reg       <= '0;
            fill_reg       <= '0;
            after_cnt_reg  <= 1'b0;
            first_dash_reg <= 1'b0;
            prev_dash_reg  <= 1'b0;
            prev_cr_reg    <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            dlen_reg       <= dlen_next;
            fill_reg       <= fill_next;
            after_cnt_reg  <= after_cnt_next;
            first_dash_reg <= first_dash_next;
            prev_dash_reg  <= prev_dash_next;
            prev_cr_reg    <= prev_cr_next;
        end
    end

    // cell j holds window byte j (0 is oldest) and delimiter byte j
    for (genvar j = 0; j < N; j++)
    begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(j);
        mbp_pkg::cell_ctl_t ctl;
        logic [7:0]         nb;

        if (j < N - 1)
        begin : g_mid
            assign nb = cell_data[j+1];
        end
        else
        begin : g_end
            assign nb = b;
        end

        if (j < 4)
        begin : g_head
            assign ctl.pat_we     = cap_start || (cr_we && IDX == dlen_reg)
                                    || (b_we && IDX == dlen1);
            assign ctl.pat_wdata  = cap_start ? mbp_pkg::delim_head_byte(2'(j))
                                    : ((cr_we && IDX == dlen_reg) ? mbp_pkg::CHAR_CR : b);
            assign ctl.use_fixed  = (phase_reg == PH_HEADERS);
            assign ctl.fixed_byte = mbp_pkg::hdr_end_byte(2'(j));
        end
        else
        begin : g_tail
            assign ctl.pat_we     = (cr_we && IDX == dlen_reg) || (b_we && IDX == dlen1);
            assign ctl.pat_wdata  = (cr_we && IDX == dlen_reg) ? mbp_pkg::CHAR_CR : b;
            assign ctl.use_fixed  = 1'b0;
            assign ctl.fixed_byte = 8'd0;
        end

        assign ctl.shift = push;
        assign ctl.entry = (IDX == hold_m1);
        assign ctl.role  = (IDX < hold)  ? mbp_pkg::ROLE_HIST :
                           (IDX == hold) ? mbp_pkg::ROLE_TAIL : mbp_pkg::ROLE_IDLE;

        mbp_cell u_cell
        (
            .clk           (clk),
            .ctl           (ctl),
            .in_byte       (b),
            .neighbor_byte (nb),
            .data          (cell_data[j]),
            .match         (cell_match[j])
        );
    end

    mbp_outq u_outq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (emit),
        .wr_data  (res),
        .full     (q_full),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (q_out)
    );

    assign m_tdata = q_out.data;
    assign m_tuser = q_out.kind;
    assign m_tlast = 1'b1;

    `MBP_ASSERT(a_fill_within_hold, clk, rst_n, (phase_reg == PH_HEADERS || phase_reg == PH_BODY) |-> fill_reg <= hold)
    `MBP_ASSERT(a_dlen_range, clk, rst_n, dlen_reg <= mbp_pkg::DELIM_MAX_CNT)
    `MBP_ASSERT(a_body_has_boundary, clk, rst_n, phase_reg == PH_BODY |-> dlen_reg > mbp_pkg::HEAD_LEN)

endmodule
